### hw/rtl/char_lcd_4bit_sequencer_defines.svh
// Assertion macros for the character LCD sequencer.
// Define ASSERT_OFF to compile every check away.
`ifndef CHAR_LCD_4BIT_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during rst
`define LCD4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LCD4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCD4_ASSERT_IMP(lbl, ante, cons, msg)
`define LCD4_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/lcd4_seq_pkg.sv
package lcd4_seq_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CMD    = 2'd1,
    OP_DATA   = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  // action kinds
  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_STROBE = 1'b1;

  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;

  localparam int STEP_W    = 5;
  localparam int INIT_LEN  = 25;
  localparam int BYTE_LEN  = 4;
  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_LEN - 1);
  localparam logic [1:0]        BYTE_LAST = 2'(BYTE_LEN - 1);

  // job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
  } req_t;

  typedef struct packed {
    logic       action_kind;
    logic       reg_select;
    logic [3:0] nibble;
    logic [4:0] wait_ms;
    logic       last;
  } action_t;

  // classified request, as held in the queue
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic action_t mk_wait(input logic [4:0] ms);
    action_t a;
    a             = '0;
    a.action_kind = ACT_WAIT;
    a.wait_ms     = ms;
    return a;
  endfunction

  function automatic action_t mk_strobe(input logic rs, input logic [3:0] nib);
    action_t a;
    a             = '0;
    a.action_kind = ACT_STROBE;
    a.reg_select  = rs;
    a.nibble      = nib;
    return a;
  endfunction

  // hi nibble, 1 ms, lo nibble, 2 ms
  function automatic action_t byte_action(input job_t j, input logic [1:0] step);
    action_t a;
    case (step)
      2'd0:    a = mk_strobe(j.rs, j.byte_val[7:4]);
      2'd1:    a = mk_wait(5'd1);
      2'd2:    a = mk_strobe(j.rs, j.byte_val[3:0]);
      default: a = mk_wait(5'd2);
    endcase
    return a;
  endfunction

  // wake-up nibbles, then 0x28, 0x0C, 0x01, extra 5 ms, 0x06
  function automatic action_t init_action(input logic [STEP_W-1:0] step);
    action_t a;
    case (step)
      5'd0:    a = mk_wait(5'd20);
      5'd1:    a = mk_strobe(1'b0, 4'h3);
      5'd2:    a = mk_wait(5'd5);
      5'd3:    a = mk_strobe(1'b0, 4'h3);
      5'd4:    a = mk_wait(5'd1);
      5'd5:    a = mk_strobe(1'b0, 4'h3);
      5'd6:    a = mk_wait(5'd1);
      5'd7:    a = mk_strobe(1'b0, 4'h2);
      5'd8:    a = mk_strobe(1'b0, 4'h2);
      5'd9:    a = mk_wait(5'd1);
      5'd10:   a = mk_strobe(1'b0, 4'h8);
      5'd11:   a = mk_wait(5'd2);
      5'd12:   a = mk_strobe(1'b0, 4'h0);
      5'd13:   a = mk_wait(5'd1);
      5'd14:   a = mk_strobe(1'b0, 4'hC);
      5'd15:   a = mk_wait(5'd2);
      5'd16:   a = mk_strobe(1'b0, 4'h0);
      5'd17:   a = mk_wait(5'd1);
      5'd18:   a = mk_strobe(1'b0, 4'h1);
      5'd19:   a = mk_wait(5'd2);
      5'd20:   a = mk_wait(5'd5);
      5'd21:   a = mk_strobe(1'b0, 4'h0);
      5'd22:   a = mk_wait(5'd1);
      5'd23:   a = mk_strobe(1'b0, 4'h6);
      5'd24:   a = mk_wait(5'd2);
      default: a = '0;
    endcase
    return a;
  endfunction

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

### hw/rtl/lcd4_seq_front.sv
module lcd4_seq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lcd4_seq_pkg::req_t   req,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output lcd4_seq_pkg::job_t   job
);

  logic               slot_valid;
  logic               take;
  lcd4_seq_pkg::job_t job_next;

  assign busy = slot_valid && q_full;
  assign take = start && !busy;
  assign push = slot_valid && !q_full;

  // classify the request into a byte job or an init job
  always_comb begin
    job_next = '0;
    case (req.operation)
      lcd4_seq_pkg::OP_INIT: begin
        job_next.is_init = 1'b1;
      end
      lcd4_seq_pkg::OP_CMD: begin
        job_next.byte_val = req.value;
      end
      lcd4_seq_pkg::OP_DATA: begin
        job_next.rs       = 1'b1;
        job_next.byte_val = req.value;
      end
      default: begin
        // cursor: line base plus column, never wraps with a 6-bit column
        job_next.byte_val = (req.row ? lcd4_seq_pkg::LINE1_BASE
                                     : lcd4_seq_pkg::LINE0_BASE) + {2'b00, req.col};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (take) begin
      slot_valid <= 1'b1;
    end else if (push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_next;
    end
  end

endmodule

### hw/rtl/lcd4_seq_fifo.sv
module lcd4_seq_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lcd4_seq_pkg::job_t    push_data,
  input  logic                  pop,
  output lcd4_seq_pkg::job_t    pop_data,
  output lcd4_seq_pkg::q_stat_t stat
);

  lcd4_seq_pkg::job_t                     mem [lcd4_seq_pkg::QDEPTH];
  logic [lcd4_seq_pkg::QPTR_W-1:0]        wr_ptr;
  logic [lcd4_seq_pkg::QPTR_W-1:0]        rd_ptr;
  logic [lcd4_seq_pkg::QCNT_W-1:0]        count;

  localparam logic [lcd4_seq_pkg::QPTR_W-1:0] PTR_END =
    lcd4_seq_pkg::QPTR_W'(lcd4_seq_pkg::QDEPTH - 1);

  assign stat.full  = (count == lcd4_seq_pkg::QCNT_W'(lcd4_seq_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_END) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_END) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/lcd4_seq_back.sv
module lcd4_seq_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  lcd4_seq_pkg::job_t    q_data,
  output logic                  pop,
  output logic                  strobe,
  output lcd4_seq_pkg::action_t result
);

  lcd4_seq_pkg::back_state_t               state;
  lcd4_seq_pkg::back_state_t               state_next;
  logic [lcd4_seq_pkg::STEP_W-1:0]         step;
  lcd4_seq_pkg::job_t                      cur;
  logic                                    last_now;

  assign last_now = (state == lcd4_seq_pkg::BK_RUN) &&
                    (cur.is_init ? (step == lcd4_seq_pkg::INIT_LAST)
                                 : (step[1:0] == lcd4_seq_pkg::BYTE_LAST));

  // next job loads on the final beat, so jobs run without a gap
  assign pop = !q_empty && ((state == lcd4_seq_pkg::BK_IDLE) || last_now);

  always_comb begin
    state_next = state;
    case (state)
      lcd4_seq_pkg::BK_IDLE: begin
        if (!q_empty) state_next = lcd4_seq_pkg::BK_RUN;
      end
      lcd4_seq_pkg::BK_RUN: begin
        if (last_now && q_empty) state_next = lcd4_seq_pkg::BK_IDLE;
      end
      default: state_next = lcd4_seq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    strobe = 1'b0;
    result = '0;
    case (state)
      lcd4_seq_pkg::BK_RUN: begin
        strobe      = 1'b1;
        result      = cur.is_init ? lcd4_seq_pkg::init_action(step)
                                  : lcd4_seq_pkg::byte_action(cur, step[1:0]);
        result.last = last_now;
      end
      default: begin
        strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcd4_seq_pkg::BK_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        step <= '0;
      end else if (state == lcd4_seq_pkg::BK_RUN) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

endmodule

### hw/rtl/char_lcd_4bit_sequencer.sv
// Four-bit character LCD sequencer: turns requests into a run of pin actions.
// Request side: present req and raise start; the beat is taken on a rising
//   edge with start high and busy low. Operations are init, command byte,
//   data byte and set cursor (row/col become a DDRAM address byte).
// Result side: one action per cycle, marked by strobe, valid that cycle only.
//   An action is a wait (wait_ms) or an enable strobe (reg_select, nibble);
//   last flags the final action of a request.
// Request path: when idle, an accepted request is registered in the front slot,
//   then the job queue, then the back's job register, before its first action shows.
// Throughput: the back sequencer emits one action per cycle while it has a job;
//   a byte request is 4 actions and init is 25; requests queued behind the
//   running one follow with no idle cycle between them.
// A front slot plus a 2-deep job queue buffer requests; busy rises only when
//   both are full, so start can run ahead of the actions being emitted.
// Reset (rst, synchronous) empties the slot and queue and idles the sequencer;
//   no action is shown until a new request comes in.
// The receiver cannot stall: every strobed beat is taken.
`include "char_lcd_4bit_sequencer_defines.svh"

module char_lcd_4bit_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lcd4_seq_pkg::req_t    req,
  output logic                  busy,
  output logic                  strobe,
  output lcd4_seq_pkg::action_t result
);

  logic                  q_push;
  logic                  q_pop;
  lcd4_seq_pkg::job_t    front_job;
  lcd4_seq_pkg::job_t    q_job;
  lcd4_seq_pkg::q_stat_t q_stat;

  // front: take the request, turn it into a byte or init job
  lcd4_seq_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .q_full (q_stat.full),
    .busy   (busy),
    .push   (q_push),
    .job    (front_job)
  );

  // job queue between front and back
  lcd4_seq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_job),
    .pop       (q_pop),
    .pop_data  (q_job),
    .stat      (q_stat)
  );

  // back: step through each job's actions, one per cycle
  lcd4_seq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_stat.empty),
    .q_data  (q_job),
    .pop     (q_pop),
    .strobe  (strobe),
    .result  (result)
  );

  // busy only when the queue is backed up
  `LCD4_ASSERT_IMP(a_busy_needs_full_q, busy, q_stat.full, "busy while queue not full")
  // a queued job means the sequencer is emitting next cycle
  `LCD4_ASSERT_NXT(a_queue_drains, !q_stat.empty, strobe, "queued job not started")
  // actions of one request come out with no gap
  `LCD4_ASSERT_NXT(a_run_unbroken, strobe && !result.last, strobe, "gap inside a request")
  // a wait carries no pin levels, a strobe no delay
  `LCD4_ASSERT_IMP(a_unused_zero, strobe, (result.action_kind == lcd4_seq_pkg::ACT_WAIT) ? (result.reg_select == 1'b0 && result.nibble == 4'h0) : (result.wait_ms == 5'd0), "unused action field set")

endmodule

### sim/tb.sv
module tb;

  // random part sizing; the calm tail runs with start held high throughout
  localparam int N_RANDOM       = 160;
  localparam int CALM_TAIL      = 30;
  // cycles with no beat on either side before the run is declared hung;
  // worst legal stretch is a sender gap plus a request's path to its first beat
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 20;

  logic                  clk;
  logic                  rst;
  logic                  start;
  lcd4_seq_pkg::req_t    req;
  logic                  busy;
  logic                  strobe;
  lcd4_seq_pkg::action_t result;

  char_lcd_4bit_sequencer u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // pin actions the sequencer still owes us, oldest first
  lcd4_seq_pkg::action_t lcd_actions_due [$];

  int err_count;
  int n_requests;
  int n_inits;
  int n_beats;
  int idle_cycles;

  // Directed rows. Where typed is set, the byte and RS level are written out by
  // hand and the four expected beats are built from them; other rows go
  // through the predictor.
  typedef struct {
    lcd4_seq_pkg::op_t op;
    logic [7:0]        value;
    logic              row;
    logic [5:0]        col;
    bit                typed;
    logic              exp_rs;
    logic [7:0]        exp_byte;
  } stim_row_t;

  stim_row_t dir_rows [N_DIRECTED] = '{
    '{lcd4_seq_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    '{lcd4_seq_pkg::OP_CMD,    8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 8'h00},
    '{lcd4_seq_pkg::OP_CMD,    8'hFF, 1'b0, 6'd0,  1'b1, 1'b0, 8'hFF},
    '{lcd4_seq_pkg::OP_DATA,   8'h00, 1'b0, 6'd0,  1'b1, 1'b1, 8'h00},
    '{lcd4_seq_pkg::OP_DATA,   8'hFF, 1'b0, 6'd0,  1'b1, 1'b1, 8'hFF},
    '{lcd4_seq_pkg::OP_DATA,   8'hA5, 1'b0, 6'd0,  1'b1, 1'b1, 8'hA5},
    '{lcd4_seq_pkg::OP_CMD,    8'h5A, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    // cursor: line bases and the column corners, inside and past the line
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b0, 6'd0,  1'b1, 1'b0, 8'h80},
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b0, 6'd39, 1'b1, 1'b0, 8'hA7},
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b1, 6'd0,  1'b1, 1'b0, 8'hC0},
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b1, 6'd39, 1'b1, 1'b0, 8'hE7},
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1, 1'b0, 8'hBF},
    '{lcd4_seq_pkg::OP_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, 1'b0, 8'hFF},
    // fields that the operation must ignore, driven nonzero
    '{lcd4_seq_pkg::OP_CURSOR, 8'hFF, 1'b0, 6'd5,  1'b1, 1'b0, 8'h85},
    '{lcd4_seq_pkg::OP_INIT,   8'hFF, 1'b1, 6'd63, 1'b0, 1'b0, 8'h00},
    '{lcd4_seq_pkg::OP_CMD,    8'h3C, 1'b1, 6'd63, 1'b1, 1'b0, 8'h3C},
    '{lcd4_seq_pkg::OP_DATA,   8'h41, 1'b1, 6'd21, 1'b1, 1'b1, 8'h41},
    // back-to-back inits with a byte behind them push the queue to full
    '{lcd4_seq_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    '{lcd4_seq_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00},
    '{lcd4_seq_pkg::OP_DATA,   8'h96, 1'b0, 6'd0,  1'b0, 1'b0, 8'h00}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic lcd4_seq_pkg::action_t wait_beat(input logic [4:0] ms);
    lcd4_seq_pkg::action_t a;
    a             = '0;
    a.action_kind = lcd4_seq_pkg::ACT_WAIT;
    a.wait_ms     = ms;
    return a;
  endfunction

  function automatic lcd4_seq_pkg::action_t strobe_beat(input logic rs,
                                                        input logic [3:0] nib);
    lcd4_seq_pkg::action_t a;
    a             = '0;
    a.action_kind = lcd4_seq_pkg::ACT_STROBE;
    a.reg_select  = rs;
    a.nibble      = nib;
    return a;
  endfunction

  function automatic void queue_beat(input lcd4_seq_pkg::action_t a, input logic fin);
    a.last = fin;
    lcd_actions_due.push_back(a);
  endfunction

  // a byte goes out high nibble, 1 ms, low nibble, 2 ms
  function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin);
    queue_beat(strobe_beat(rs, b[7:4]), 1'b0);
    queue_beat(wait_beat(5'd1), 1'b0);
    queue_beat(strobe_beat(rs, b[3:0]), 1'b0);
    queue_beat(wait_beat(5'd2), fin);
  endfunction

  function automatic void predict_lcd_actions(input lcd4_seq_pkg::req_t r);
    logic [7:0] addr;
    case (lcd4_seq_pkg::op_t'(r.operation))
      lcd4_seq_pkg::OP_INIT: begin
        // wake-up nibbles 3,3,3,2 with RS low, then function set, display on,
        // clear (plus 5 ms settle) and entry mode
        queue_beat(wait_beat(5'd20), 1'b0);
        queue_beat(strobe_beat(1'b0, 4'h3), 1'b0);
        queue_beat(wait_beat(5'd5), 1'b0);
        queue_beat(strobe_beat(1'b0, 4'h3), 1'b0);
        queue_beat(wait_beat(5'd1), 1'b0);
        queue_beat(strobe_beat(1'b0, 4'h3), 1'b0);
        queue_beat(wait_beat(5'd1), 1'b0);
        queue_beat(strobe_beat(1'b0, 4'h2), 1'b0);
        queue_byte(1'b0, 8'h28, 1'b0);
        queue_byte(1'b0, 8'h0C, 1'b0);
        queue_byte(1'b0, 8'h01, 1'b0);
        queue_beat(wait_beat(5'd5), 1'b0);
        queue_byte(1'b0, 8'h06, 1'b1);
      end
      lcd4_seq_pkg::OP_CMD:  queue_byte(1'b0, r.value, 1'b1);
      lcd4_seq_pkg::OP_DATA: queue_byte(1'b1, r.value, 1'b1);
      default: begin
        // column adds to the line base as is; 6 bits never carry out of a byte
        addr = (r.row ? lcd4_seq_pkg::LINE1_BASE : lcd4_seq_pkg::LINE0_BASE)
               + {2'b00, r.col};
        queue_byte(1'b0, addr, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result checker: every strobed beat is compared against the oldest due one
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    lcd4_seq_pkg::action_t due;
    if (!rst && strobe !== 1'b0) begin
      n_beats++;
      if (lcd_actions_due.size() == 0) begin
        $error("beat with nothing due: kind %0b rs %0b nibble %0h wait %0d last %0b",
               result.action_kind, result.reg_select, result.nibble,
               result.wait_ms, result.last);
        err_count++;
      end else begin
        due = lcd_actions_due.pop_front();
        check_field("action_kind", 8'(due.action_kind), 8'(result.action_kind));
        check_field("reg_select",  8'(due.reg_select),  8'(result.reg_select));
        check_field("nibble",      8'(due.nibble),      8'(result.nibble));
        check_field("wait_ms",     8'(due.wait_ms),     8'(result.wait_ms));
        check_field("last",        8'(due.last),        8'(result.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles in which no beat moves on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d actions still due", lcd_actions_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drive one request at the falling edge and hold it until an edge sees busy
  // low. start is left high so the next request can follow without a gap.
  task automatic send_request(input lcd4_seq_pkg::req_t r, input bit typed,
                              input logic rs, input logic [7:0] b);
    @(negedge clk);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) queue_byte(rs, b, 1'b1);
    else       predict_lcd_actions(r);
    n_requests++;
    if (lcd4_seq_pkg::op_t'(r.operation) == lcd4_seq_pkg::OP_INIT) n_inits++;
  endtask

  // drop start for a sender gap; req carries noise that must be ignored
  task automatic sender_gap(input int n);
    @(negedge clk);
    start <= 1'b0;
    req   <= lcd4_seq_pkg::req_t'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // hold off until the sequencer has emitted everything owed
  task automatic drain_actions();
    @(negedge clk);
    start <= 1'b0;
    while (lcd_actions_due.size() != 0) @(posedge clk);
  endtask

  function automatic lcd4_seq_pkg::req_t random_request();
    lcd4_seq_pkg::req_t r;
    r.value = 8'($urandom_range(0, 255));
    r.row   = 1'($urandom_range(0, 1));
    // mostly on-screen columns, some past the 40-char line
    if ($urandom_range(0, 3) == 0) r.col = 6'($urandom_range(40, 63));
    else                           r.col = 6'($urandom_range(0, 39));
    // init is long, so keep it rare
    if ($urandom_range(0, 9) == 0) r.operation = lcd4_seq_pkg::OP_INIT;
    else                           r.operation = 2'($urandom_range(1, 3));
    return r;
  endfunction

  initial begin
    lcd4_seq_pkg::req_t r;
    err_count  = 0;
    n_requests = 0;
    n_inits    = 0;
    n_beats    = 0;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < N_DIRECTED; i++) begin
      r.operation = dir_rows[i].op;
      r.value     = dir_rows[i].value;
      r.row       = dir_rows[i].row;
      r.col       = dir_rows[i].col;
      // the last rows run back to back to push the queue to full
      if (i > 0 && i < N_DIRECTED - 3 && $urandom_range(0, 2) == 0)
        sender_gap($urandom_range(1, 5));
      send_request(r, dir_rows[i].typed, dir_rows[i].exp_rs, dir_rows[i].exp_byte);
    end
    drain_actions();

    // random part: bursty sender gaps, none in the tail
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) drain_actions();
      if (k < N_RANDOM - CALM_TAIL && $urandom_range(0, 2) == 0)
        sender_gap($urandom_range(1, 5));
      send_request(random_request(), 1'b0, 1'b0, 8'h00);
    end

    drain_actions();
    // give any stray beat time to show before the summary
    repeat (8) @(posedge clk);

    $display("covered %0d requests (%0d init, all ops, cursor columns 0..63) with %0d beats",
             n_requests, n_inits, n_beats);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
